[rtl/zle_pkg.sv]
// zle_pkg: shared types and constants of the zip local header name extractor
// no dependencies

package zle_pkg;

    localparam logic [7:0] SIG_P  = 8'h50;
    localparam logic [7:0] SIG_K  = 8'h4b;
    localparam logic [7:0] SIG_LO = 8'h03;
    localparam logic [7:0] SIG_HI = 8'h04;
    localparam logic [7:0] LIKE_LIMIT = 8'd7;

    localparam logic [4:0] OFF_SIG_DONE = 5'd3;
    localparam logic [4:0] OFF_FIRST    = 5'd4;
    localparam logic [4:0] OFF_LEN_LO   = 5'd26;
    localparam logic [4:0] OFF_LEN_HI   = 5'd27;
    localparam logic [4:0] OFF_LAST_HDR = 5'd29;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_HEADER = 3'b010,
        PH_NAME   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_last;
        logic       name_empty;
        logic       is_summary;
        logic       archive_seen;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[rtl/zle_parser.sv]
// zle_parser: byte-wise header scanner state and next-state logic
// depends on zle_pkg

module zle_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            file_end,
    output zle_pkg::push_t  push
);
    import zle_pkg::*;

    logic [23:0] recent_reg, recent_next;
    phase_t      phase_reg, phase_next;
    logic [4:0]  hoff_reg, hoff_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] nrem_reg, nrem_next;
    logic        seen_reg, seen_next;

    logic [7:0] p2, p1, p0;
    logic       pk;
    logic       have_name;
    result_t    name_res;
    result_t    summ_res;

    assign p2 = recent_reg[23:16];
    assign p1 = recent_reg[15:8];
    assign p0 = recent_reg[7:0];
    assign pk = (p2 == SIG_P) && (p1 == SIG_K);

    always_comb begin
        recent_next = {recent_reg[15:0], data_byte};
        phase_next  = phase_reg;
        hoff_next   = hoff_reg;
        nlen_next   = nlen_reg;
        nrem_next   = nrem_reg;
        seen_next   = seen_reg;
        have_name   = 1'b0;
        name_res    = '0;

        if (pk && (p0 < LIKE_LIMIT) && (data_byte < LIKE_LIMIT)) begin
            seen_next = 1'b1;
        end

        unique case (phase_reg)
            PH_HEADER: begin
                if (hoff_reg == OFF_LEN_LO) begin
                    nlen_next = {nlen_reg[15:8], data_byte};
                end else if (hoff_reg == OFF_LEN_HI) begin
                    nlen_next = {data_byte, nlen_reg[7:0]};
                end
                if (hoff_reg >= OFF_LAST_HDR) begin
                    if (nlen_reg == 16'd0) begin
                        have_name           = 1'b1;
                        name_res.name_last  = 1'b1;
                        name_res.name_empty = 1'b1;
                        phase_next          = PH_HUNT;
                        hoff_next           = '0;
                    end else begin
                        nrem_next  = nlen_reg;
                        phase_next = PH_NAME;
                    end
                end else begin
                    hoff_next = hoff_reg + 5'd1;
                end
            end
            PH_NAME: begin
                have_name          = 1'b1;
                name_res.name_byte = data_byte;
                name_res.name_last = (nrem_reg <= 16'd1);
                nrem_next          = nrem_reg - 16'd1;
                if (nrem_reg <= 16'd1) begin
                    nrem_next  = '0;
                    phase_next = PH_HUNT;
                    hoff_next  = '0;
                end
            end
            default: begin
                if ((hoff_reg >= OFF_SIG_DONE) && pk && (p0 == SIG_LO)
                        && (data_byte == SIG_HI)) begin
                    phase_next = PH_HEADER;
                    hoff_next  = OFF_FIRST;
                    nlen_next  = '0;
                end else begin
                    phase_next = PH_HUNT;
                    if (hoff_reg < OFF_SIG_DONE) begin
                        hoff_next = hoff_reg + 5'd1;
                    end else begin
                        hoff_next = OFF_SIG_DONE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        summ_res              = '0;
        summ_res.is_summary   = 1'b1;
        summ_res.archive_seen = seen_next;
        push = '0;
        if (accept) begin
            if (have_name) begin
                push.first = name_res;
                if (file_end) begin
                    push.num    = 2'd2;
                    push.second = summ_res;
                end else begin
                    push.num = 2'd1;
                end
            end else if (file_end) begin
                push.num   = 2'd1;
                push.first = summ_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            phase_reg  <= PH_HUNT;
            hoff_reg   <= '0;
            nlen_reg   <= '0;
            nrem_reg   <= '0;
            seen_reg   <= 1'b0;
        end else if (accept) begin
            if (file_end) begin
                recent_reg <= '0;
                phase_reg  <= PH_HUNT;
                hoff_reg   <= '0;
                nlen_reg   <= '0;
                nrem_reg   <= '0;
                seen_reg   <= 1'b0;
            end else begin
                recent_reg <= recent_next;
                phase_reg  <= phase_next;
                hoff_reg   <= hoff_next;
                nlen_reg   <= nlen_next;
                nrem_reg   <= nrem_next;
                seen_reg   <= seen_next;
            end
        end
    end

    // header offsets stay within the fixed header
    a_hdr_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (hoff_reg >= OFF_FIRST && hoff_reg <= OFF_LAST_HDR))
        else $error("header offset out of range");

    // a name in progress always has bytes left
    a_name_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME) |-> (nrem_reg != 16'd0))
        else $error("name phase with nothing remaining");

endmodule

[rtl/zle_out_queue.sv]
// zle_out_queue: small result queue, up to two pushes and one pop per cycle
// depends on zle_pkg

module zle_out_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  zle_pkg::push_t             push,
    input  logic                       pop,
    output logic                       not_empty,
    output logic                       two_free,
    output zle_pkg::result_t           head
);
    import zle_pkg::*;

    result_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_inc;
    logic                do_pop;

    assign not_empty  = (count_reg != '0);
    assign two_free   = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && not_empty;
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);
    assign count_next = count_reg + QCNT_W'(push.num) - QCNT_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            slot_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.num);
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> (QCNT_W'(push.num) + count_reg <= QCNT_W'(QDEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == 2'd0 && !pop) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved while idle");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH) &&
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

[rtl/zip_local_header_name_extractor.sv]
// zip_local_header_name_extractor: top level, parser feeding a result queue
// depends on zle_pkg, zle_parser, zle_out_queue
//
// usage:
//   s_ channel takes one file byte per item (s_data_byte) with s_file_end
//   set on the last byte of the file. m_ channel delivers name results
//   (one item per name byte, name_last on the final byte, name_empty for a
//   zero-length name) and one summary item per file (is_summary, with
//   archive_seen set if a ZIP-like signature occurred).
//   latency: a result is offered on m_ in the cycle after its byte is
//   accepted when no earlier result waits ahead of it.
//   throughput: one byte per cycle while s_ready is high; parser state
//   updates in the cycle of acceptance; results go into a four-entry queue.
//   s_ready is high while the queue has two free entries, so a stalled
//   receiver holds off input once three results wait; bytes that give no
//   result add nothing to the queue. the end-of-file byte that also ends a
//   name yields two results in order.
//   reset (aresetn low, synchronous) empties the queue and returns the parser
//   to signature hunting; the parser also returns there after each file end.

module zip_local_header_name_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_file_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_name_byte,
    output logic       m_name_last,
    output logic       m_name_empty,
    output logic       m_is_summary,
    output logic       m_archive_seen
);
    import zle_pkg::*;

    push_t   push;
    result_t head;
    logic    two_free;
    logic    s_accept;

    assign s_ready  = two_free;
    assign s_accept = s_valid && two_free;

    zle_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_byte (s_data_byte),
        .file_end  (s_file_end),
        .push      (push)
    );

    zle_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_ready),
        .not_empty (m_valid),
        .two_free  (two_free),
        .head      (head)
    );

    assign m_name_byte    = head.name_byte;
    assign m_name_last    = head.name_last;
    assign m_name_empty   = head.name_empty;
    assign m_is_summary   = head.is_summary;
    assign m_archive_seen = head.archive_seen;

endmodule
